>>> sv/urlpd_pkg.sv
// Shared types, character codes and digit decoding for the URL percent decoder.
package urlpd_pkg;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [5:0] LETTER_BASE  = 6'd10;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       byte_present;
    logic       text_done;
  } out_item_t;

  // Escape phase, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_t;

  // Value of one escape digit; bytes that are not letters or digits count as 48.
  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'd0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      diff = c - CHAR_UPPER_A;
      return diff[5:0] + LETTER_BASE;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      diff = c - CHAR_LOWER_A;
      return diff[5:0] + LETTER_BASE;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff = c - CHAR_ZERO;
      return diff[5:0];
    end
    return CHAR_ZERO[5:0];
  endfunction

endpackage

>>> sv/urlpd_stream_if.sv
// Valid/ready stream interface used for the decoder's input and result channels.
interface urlpd_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/urlpd_in_stage.sv
// Input register: captures one encoded byte per transfer.
module urlpd_in_stage (
  input  logic                clk,
  input  logic                rst,
  urlpd_stream_if.sink        text_in,
  input  logic                take,
  output logic                stage_valid,
  output urlpd_pkg::in_item_t stage_item
);

  assign text_in.ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (text_in.ready) begin
      stage_valid <= text_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      stage_item <= text_in.data;
    end
  end

endmodule

>>> sv/urlpd_decode.sv
// Escape state machine and byte decoding between the input and result registers.
module urlpd_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 stage_valid,
  input  urlpd_pkg::in_item_t  stage_item,
  input  logic                 out_free,
  output logic                 take,
  output logic                 load,
  output urlpd_pkg::out_item_t result
);

  urlpd_pkg::phase_t phase;
  urlpd_pkg::phase_t phase_next;
  logic [3:0]        high_digit;
  logic [5:0]        digit;
  logic              emit;
  logic              have;
  logic [7:0]        value;

  assign digit = urlpd_pkg::digit_value(stage_item.text_byte);

  always_comb begin
    have       = 1'b0;
    value      = 8'd0;
    phase_next = urlpd_pkg::PH_IDLE;
    case (phase)
      urlpd_pkg::PH_HIGH: begin
        phase_next = urlpd_pkg::PH_LOW;
      end
      urlpd_pkg::PH_LOW: begin
        // Only the low four bits of the high digit survive the wrap to a byte.
        value = {high_digit, 4'd0} + {2'd0, digit};
        have  = 1'b1;
      end
      default: begin
        if (stage_item.text_byte == urlpd_pkg::CHAR_PLUS) begin
          value = urlpd_pkg::CHAR_SPACE;
          have  = 1'b1;
        end else if (stage_item.text_byte == urlpd_pkg::CHAR_PCT) begin
          phase_next = urlpd_pkg::PH_HIGH;
        end else begin
          value = stage_item.text_byte;
          have  = 1'b1;
        end
      end
    endcase
    if (stage_item.text_end) begin
      phase_next = urlpd_pkg::PH_IDLE;
    end
  end

  assign emit = have || stage_item.text_end;
  assign take = stage_valid && (!emit || out_free);
  assign load = stage_valid && emit && out_free;

  assign result.plain_byte   = have ? value : 8'd0;
  assign result.byte_present = have;
  assign result.text_done    = stage_item.text_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= urlpd_pkg::PH_IDLE;
      high_digit <= 4'd0;
    end else if (take) begin
      phase <= phase_next;
      if (stage_item.text_end) begin
        high_digit <= 4'd0;
      end else if (phase == urlpd_pkg::PH_HIGH) begin
        high_digit <= digit[3:0];
      end
    end
  end

  // The end of a text always leaves the decoder outside any escape.
  a_end_resets_phase: assert property (@(posedge clk) disable iff (rst)
    take && stage_item.text_end |=> phase == urlpd_pkg::PH_IDLE)
    else $error("escape phase not cleared after end of text");

  // A pending high digit produces no result unless it ends the text.
  a_high_digit_silent: assert property (@(posedge clk) disable iff (rst)
    take && phase == urlpd_pkg::PH_HIGH && !stage_item.text_end |-> !load)
    else $error("result emitted for a pending high digit");

  // Every result carries a byte or marks the end of a text.
  a_result_meaningful: assert property (@(posedge clk) disable iff (rst)
    load |-> result.byte_present || result.text_done)
    else $error("empty result emitted");

  // A low digit always completes the escape with a byte.
  a_low_digit_emits: assert property (@(posedge clk) disable iff (rst)
    stage_valid && phase == urlpd_pkg::PH_LOW |-> have)
    else $error("low digit did not produce a byte");

endmodule

>>> sv/urlpd_out_stage.sv
// Result register: holds one decoded result until the sink takes it.
module urlpd_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  urlpd_stream_if.source       plain_out,
  input  logic                 load,
  input  urlpd_pkg::out_item_t result,
  output logic                 out_free
);

  logic                 valid;
  urlpd_pkg::out_item_t data;

  assign out_free        = !valid || plain_out.ready;
  assign plain_out.valid = valid;
  assign plain_out.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

endmodule

>>> sv/url_percent_decoder.sv
// URL percent decoder, top level.
// Decodes an encoded text one byte per clock: '+' becomes a space, '%' followed by two
// bytes becomes one byte, any other byte passes through, and the last byte of a text
// always yields a result with text_done set. Each transfer goes through an input
// register and a result register, and a result is presented on plain_out once its
// byte has left the input register and been loaded into the result register.
// The decoder sustains one byte per cycle as long as the result side keeps taking
// results, with text_in.ready following plain_out.ready combinationally.
// Bytes that start an escape or carry its first digit give no result unless they end
// the text.
module url_percent_decoder (
  input  logic           clk,
  input  logic           rst,
  urlpd_stream_if.sink   text_in,
  urlpd_stream_if.source plain_out
);

  logic                 take;
  logic                 load;
  logic                 out_free;
  logic                 stage_valid;
  urlpd_pkg::in_item_t  stage_item;
  urlpd_pkg::out_item_t result;

  urlpd_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .text_in     (text_in),
    .take        (take),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  urlpd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .out_free    (out_free),
    .take        (take),
    .load        (load),
    .result      (result)
  );

  urlpd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .plain_out (plain_out),
    .load      (load),
    .result    (result),
    .out_free  (out_free)
  );

endmodule

>>> tb/url_percent_decoder_tb.sv
// Self-checking testbench for the URL percent decoder: directed table plus random texts.
`timescale 1ns / 1ps

module url_percent_decoder_tb;

  localparam int RANDOM_ITEMS = 800;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIR_COUNT    = 24;

  // One directed row: the input byte, and a typed-in result where it is obvious.
  typedef struct packed {
    urlpd_pkg::in_item_t  item;
    logic                 fixed;
    urlpd_pkg::out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  urlpd_stream_if #(.payload_t(urlpd_pkg::in_item_t))  text_in_if ();
  urlpd_stream_if #(.payload_t(urlpd_pkg::out_item_t)) plain_out_if ();

  url_percent_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in_if),
    .plain_out (plain_out_if)
  );

  always #4 clk = ~clk;

  // Decoder state as predicted by the testbench.
  urlpd_pkg::phase_t esc_phase = urlpd_pkg::PH_IDLE;
  logic [5:0]        hi_digit  = 6'd0;

  urlpd_pkg::out_item_t expected_plain [$];
  urlpd_pkg::in_item_t  text_q [$];
  int                   errors      = 0;
  int                   idle_cycles = 0;
  int                   results_seen = 0;
  urlpd_pkg::out_item_t got_want;

  // Columns: text_byte, text_end, fixed, plain_byte, byte_present, text_done.
  dir_row_t dir_rows [DIR_COUNT] = '{
    {8'h61, 1'b0, 1'b1, 8'h61, 1'b1, 1'b0},   // plain letter
    {8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0},   // top byte passes through
    {8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0},   // zero byte passes through
    {8'h2B, 1'b0, 1'b1, 8'h20, 1'b1, 1'b0},   // plus becomes a space
    {8'h25, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h46, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h66, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0},   // %Ff
    {8'h25, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h34, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h31, 1'b0, 1'b1, 8'h41, 1'b1, 1'b0},   // %41
    {8'h25, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h7A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h7A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},   // %zz wraps
    {8'h25, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},   // non-digits count as 48
    {8'h25, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},   // escape opened on the last byte
    {8'h25, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h5A, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},   // first digit is the last byte
    {8'h78, 1'b1, 1'b1, 8'h78, 1'b1, 1'b1},   // one-byte text
    {8'h25, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h5A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    {8'h39, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},   // escape completed on the last byte
    {8'h2B, 1'b1, 1'b1, 8'h20, 1'b1, 1'b1}
  };

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] tmp;
    tmp = urlpd_pkg::CHAR_ZERO;
    if (c >= urlpd_pkg::CHAR_UPPER_A && c <= urlpd_pkg::CHAR_UPPER_Z) begin
      tmp = c - urlpd_pkg::CHAR_UPPER_A + 8'd10;
    end else if (c >= urlpd_pkg::CHAR_LOWER_A && c <= urlpd_pkg::CHAR_LOWER_Z) begin
      tmp = c - urlpd_pkg::CHAR_LOWER_A + 8'd10;
    end else if (c >= urlpd_pkg::CHAR_ZERO && c <= urlpd_pkg::CHAR_NINE) begin
      tmp = c - urlpd_pkg::CHAR_ZERO;
    end
    return tmp[5:0];
  endfunction

  // Advances the predicted state by one byte; returns 1 when the byte yields a result.
  function automatic bit decode_byte(input urlpd_pkg::in_item_t it,
                                     output urlpd_pkg::out_item_t res);
    logic [5:0] lo;
    bit         has;
    has = 1'b0;
    res = '0;
    case (esc_phase)
      urlpd_pkg::PH_HIGH: begin
        hi_digit  = digit_of(it.text_byte);
        esc_phase = urlpd_pkg::PH_LOW;
      end
      urlpd_pkg::PH_LOW: begin
        lo = digit_of(it.text_byte);
        res.plain_byte = {hi_digit[3:0], 4'b0000} + {2'b00, lo};
        has = 1'b1;
        esc_phase = urlpd_pkg::PH_IDLE;
      end
      default: begin
        esc_phase = urlpd_pkg::PH_IDLE;
        if (it.text_byte == urlpd_pkg::CHAR_PLUS) begin
          res.plain_byte = urlpd_pkg::CHAR_SPACE;
          has = 1'b1;
        end else if (it.text_byte == urlpd_pkg::CHAR_PCT) begin
          esc_phase = urlpd_pkg::PH_HIGH;
        end else begin
          res.plain_byte = it.text_byte;
          has = 1'b1;
        end
      end
    endcase
    if (it.text_end) begin
      esc_phase = urlpd_pkg::PH_IDLE;
      hi_digit  = 6'd0;
    end
    res.byte_present = has;
    res.text_done    = it.text_end;
    return has || it.text_end;
  endfunction

  function automatic logic [7:0] pick_digit_byte();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0, 1:    b = urlpd_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
      2:       b = urlpd_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25));
      3:       b = urlpd_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25));
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  task automatic add_text_byte(input logic [7:0] b);
    urlpd_pkg::in_item_t it;
    it.text_byte = b;
    it.text_end  = 1'b0;
    text_q.push_back(it);
  endtask

  // Presents one byte after a gap, records its expected result, and waits for the transfer.
  task automatic send_byte(input urlpd_pkg::in_item_t it, input bit fixed,
                           input urlpd_pkg::out_item_t want, input int gap);
    urlpd_pkg::out_item_t res;
    bit                   has;
    if (gap > 0) begin
      text_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_in_if.valid <= 1'b1;
    text_in_if.data  <= it;
    has = decode_byte(it, res);
    if (fixed) res = want;
    if (has) expected_plain.push_back(res);
    do @(posedge clk); while (!(text_in_if.valid && text_in_if.ready));
  endtask

  task automatic drain_results();
    text_in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_plain.size() != 0) @(posedge clk);
  endtask

  initial begin
    text_in_if.valid   <= 1'b0;
    text_in_if.data    <= '0;
    plain_out_if.ready <= 1'b0;
  end

  // Result side: random ready stalls before transfers, none during every third 40 results.
  initial begin : result_ready
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (((results_seen / 40) % 3) == 0) ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        plain_out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      plain_out_if.ready <= 1'b1;
      do @(posedge clk); while (!(plain_out_if.valid && plain_out_if.ready));
    end
  end

  always @(posedge clk) begin
    if (!rst && plain_out_if.valid && plain_out_if.ready) begin
      results_seen++;
      if (expected_plain.size() == 0) begin
        $error("result with no expectation: plain_byte %h byte_present %b text_done %b",
               plain_out_if.data.plain_byte, plain_out_if.data.byte_present,
               plain_out_if.data.text_done);
        errors++;
      end else begin
        got_want = expected_plain.pop_front();
        if (plain_out_if.data.plain_byte !== got_want.plain_byte) begin
          $error("plain_byte: expected %h, got %h", got_want.plain_byte,
                 plain_out_if.data.plain_byte);
          errors++;
        end
        if (plain_out_if.data.byte_present !== got_want.byte_present) begin
          $error("byte_present: expected %b, got %b", got_want.byte_present,
                 plain_out_if.data.byte_present);
          errors++;
        end
        if (plain_out_if.data.text_done !== got_want.text_done) begin
          $error("text_done: expected %b, got %b", got_want.text_done,
                 plain_out_if.data.text_done);
          errors++;
        end
      end
    end
  end

  // Ends the run if no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (rst || (text_in_if.valid && text_in_if.ready) ||
        (plain_out_if.valid && plain_out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent;
    int len;
    int kind;
    int text_count;
    bit fast;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_COUNT; i++) begin
      send_byte(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want, $urandom_range(0, 3));
    end
    drain_results();

    sent = 0;
    text_count = 0;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      text_q.delete();
      // Mostly well-formed escapes and plain text; truncation leaves some escapes cut short.
      while (text_q.size() < len) begin
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
          add_text_byte(urlpd_pkg::CHAR_PCT);
          add_text_byte(pick_digit_byte());
          add_text_byte(pick_digit_byte());
        end else if (kind == 4) begin
          add_text_byte(urlpd_pkg::CHAR_PLUS);
        end else if (kind == 5) begin
          add_text_byte(8'($urandom_range(0, 255)));
        end else begin
          add_text_byte(8'($urandom_range(8'h21, 8'h7E)));
        end
      end
      while (text_q.size() > len) void'(text_q.pop_back());
      text_q[len - 1].text_end = 1'b1;

      if (text_count == 25 || text_count == 70) drain_results();
      fast = ($urandom_range(0, 3) == 0);
      foreach (text_q[k]) begin
        send_byte(text_q[k], 1'b0, '0, fast ? 0 : $urandom_range(0, 3));
      end
      sent += len;
      text_count++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_plain.size() != 0) begin
      $error("%0d expected results never arrived", expected_plain.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
